### rtl/mmcn_pkg.sv
// Shared types and constants for the min/max calibrated normaliser.
// No dependencies.
package mmcn_pkg;
	localparam int DEB_W = 16;
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd200;
	localparam int TICK_W = 32;
	localparam int LEVEL_W = 17;
	localparam int LANES = 3;
endpackage

### rtl/minmax_calibrated_normalizer_top.sv
// Top level of the min/max calibrated normaliser: debounce, mode control,
// three parallel lanes and the merging output register. Depends on mmcn_pkg, mmcn_lane.
// When calibrating or on a degenerate range each lane answers without dividing; otherwise the
// result comes from the bit-per-cycle divider in each lane, and no new beat is accepted until
// the last one has been taken. One beat in flight at a time. Asynchronous active-low reset
// clears mode, extremes, held samples and the debounce register to 200.
module minmax_calibrated_normalizer_top #(
	parameter int PEDAL_BITS = 12,
	parameter int FORCE_BITS = 24,
	parameter int FRACTION_BITS = 16,
	parameter int PEDAL_RAW_MAX = 4095,
	parameter int PEDAL_RAW_MIN = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mmcn_pkg::DEB_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tick_now, switch_level, pedal_sample, tiller_valid, left_force, right_force
	input  logic [((mmcn_pkg::TICK_W+2*FORCE_BITS+PEDAL_BITS+2+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// calibrating, entered_pulse, save_pulse, pedal_level, left_level, right_level
	output logic [((3*FRACTION_BITS+6+7)/8)*8-1:0] m_axis_tdata
);
	import mmcn_pkg::*;
	localparam int IW = ((TICK_W+2*FORCE_BITS+PEDAL_BITS+2+7)/8)*8;
	localparam int OW = ((3*FRACTION_BITS+6+7)/8)*8;
	localparam int LW = FRACTION_BITS + 1;
	localparam int PX = FORCE_BITS;
	localparam int P0 = TICK_W;
	localparam int P1 = P0 + 1;
	localparam int P2 = P1 + PEDAL_BITS;
	localparam int P3 = P2 + 1;
	localparam int P4 = P3 + FORCE_BITS;

	logic [DEB_W-1:0] deb_q;
	logic mode_q, prev_q, busy_q, ent_q, sav_q;
	logic [TICK_W-1:0] last_q;
	logic signed [FORCE_BITS-1:0] lh_q, rh_q;
	logic [LANES-1:0] got_q, dn;
	logic [FRACTION_BITS:0] lv [LANES];
	logic [FRACTION_BITS:0] res_q [LANES];
	logic acc, samp, mode_n, ent_n, sav_n, start;
	logic signed [FORCE_BITS-1:0] lx, rx;
	logic [TICK_W-1:0] tick;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q && !m_axis_tvalid;
	assign tick = s_axis_tdata[TICK_W-1:0];
	assign samp = (tick - last_q) >= TICK_W'(deb_q);
	assign mode_n = samp ? !s_axis_tdata[P0] : mode_q;
	assign ent_n = samp && mode_n && !prev_q;
	assign sav_n = samp && !mode_n && prev_q;
	assign lx = s_axis_tdata[P2] ? s_axis_tdata[P4-1:P3] : lh_q;
	assign rx = s_axis_tdata[P2] ? s_axis_tdata[P4+FORCE_BITS-1:P4] : rh_q;
	assign start = acc;

	mmcn_lane #(.XW(PEDAL_BITS), .FB(FRACTION_BITS),
		.DEF_LO((PEDAL_BITS+1)'(PEDAL_RAW_MAX)), .DEF_HI((PEDAL_BITS+1)'(PEDAL_RAW_MIN))) u_ped (
		.clk, .arst_n, .start, .restore(ent_n), .track(mode_n),
		.x({1'b0, s_axis_tdata[P1+PEDAL_BITS-1:P1]}), .done(dn[0]), .level(lv[0]));
	mmcn_lane #(.XW(PX), .FB(FRACTION_BITS),
		.DEF_LO((PX+1)'(32767)), .DEF_HI(-(PX+1)'(32768))) u_lft (
		.clk, .arst_n, .start, .restore(ent_n), .track(mode_n),
		.x({lx[FORCE_BITS-1], lx}), .done(dn[1]), .level(lv[1]));
	mmcn_lane #(.XW(PX), .FB(FRACTION_BITS),
		.DEF_LO((PX+1)'(32767)), .DEF_HI(-(PX+1)'(32768))) u_rgt (
		.clk, .arst_n, .start, .restore(ent_n), .track(mode_n),
		.x({rx[FORCE_BITS-1], rx}), .done(dn[2]), .level(lv[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= DEBOUNCE_RESET;
			mode_q <= 1'b0;
			prev_q <= 1'b0;
			last_q <= '0;
			lh_q <= '0;
			rh_q <= '0;
			busy_q <= 1'b0;
			got_q <= '0;
			m_axis_tvalid <= 1'b0;
			ent_q <= 1'b0;
			sav_q <= 1'b0;
		end else begin
			if (cfg_we) deb_q <= cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (acc) begin
				lh_q <= lx;
				rh_q <= rx;
				if (samp) begin
					last_q <= tick;
					prev_q <= mode_n;
				end
				mode_q <= mode_n;
				ent_q <= ent_n;
				sav_q <= sav_n;
				busy_q <= 1'b1;
				got_q <= '0;
			end else if (busy_q) begin
				for (int i = 0; i < LANES; i++) begin
					if (dn[i]) begin
						got_q[i] <= 1'b1;
						res_q[i] <= lv[i];
					end
				end
				if ((got_q | dn) == '1) begin
					busy_q <= 1'b0;
					m_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[0] = mode_q;
		m_axis_tdata[1] = ent_q;
		m_axis_tdata[2] = sav_q;
		m_axis_tdata[3 +: LW] = mode_q ? '0 : LW'((LW'(1) << FRACTION_BITS) - res_q[0]);
		m_axis_tdata[3+LW +: LW] = res_q[1];
		m_axis_tdata[3+2*LW +: LW] = res_q[2];
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("accept while busy");
	a_pulses_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(ent_q && sav_q)) else $error("both pulses");
	a_entered_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && ent_q) |-> mode_q) else $error("entered without mode");
endmodule

### rtl/mmcn_lane.sv
// One normalising lane: extreme tracking and a shared-width restoring divider.
// Depends on mmcn_pkg.
module mmcn_lane #(
	parameter int XW = 24,
	parameter int FB = 16,
	parameter logic signed [XW:0] DEF_LO = 25'sd32767,
	parameter logic signed [XW:0] DEF_HI = -25'sd32768
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 restore,
	input  logic                 track,
	input  logic signed [XW:0]   x,
	output logic                 done,
	output logic [FB:0]          level
);
	import mmcn_pkg::*;
	localparam int DW = XW + 2;
	localparam int CW = $clog2(FB + 1) + 1;
	logic signed [XW:0] lo_q, hi_q;
	logic signed [DW-1:0] num, den;
	logic [DW-1:0] rem_q, den_q;
	logic [FB:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [DW:0] trial;
	logic signed [XW:0] lo_eff, hi_eff;

	assign lo_eff = restore ? DEF_LO : lo_q;
	assign hi_eff = restore ? DEF_HI : hi_q;
	assign num = DW'(x) - DW'(lo_eff);
	assign den = DW'(hi_eff) - DW'(lo_eff);
	assign trial = {rem_q, 1'b0} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= DEF_LO;
			hi_q <= DEF_HI;
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				if (track) begin
					lo_q <= (x < lo_eff) ? x : lo_eff;
					hi_q <= (x > hi_eff) ? x : hi_eff;
					level <= '0;
					done <= 1'b1;
				end else if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
					level <= '0;
					done <= 1'b1;
				end else begin
					rem_q <= num < 0 ? DW'(-num) : DW'(num);
					den_q <= den < 0 ? DW'(-den) : DW'(den);
					quo_q <= '0;
					cnt_q <= CW'(FB + 1);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == CW'(FB + 1)) begin
					if (rem_q >= den_q) begin
						level <= (FB+1)'(1) << FB;
						busy_q <= 1'b0;
						done <= 1'b1;
					end
					cnt_q <= CW'(FB);
				end else begin
					if (!trial[DW]) begin
						rem_q <= trial[DW-1:0];
						quo_q <= {quo_q[FB-1:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DW-2:0], 1'b0};
						quo_q <= {quo_q[FB-1:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						busy_q <= 1'b0;
						done <= 1'b1;
						level <= trial[DW] ? {quo_q[FB-1:0], 1'b0} : {quo_q[FB-1:0], 1'b1};
					end
				end
			end
		end
	end
endmodule
